/* sv/olr_pkg.sv */
// shared constants for the octant line rasterizer
package olr_pkg;

  // default coordinate width of the endpoint and pixel fields
  localparam int COORD_BITS_DEF = 12;

  // request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // octant codes
  localparam logic [2:0] OCT_0 = 3'd0;
  localparam logic [2:0] OCT_1 = 3'd1;
  localparam logic [2:0] OCT_2 = 3'd2;
  localparam logic [2:0] OCT_3 = 3'd3;
  localparam logic [2:0] OCT_4 = 3'd4;
  localparam logic [2:0] OCT_5 = 3'd5;
  localparam logic [2:0] OCT_6 = 3'd6;
  localparam logic [2:0] OCT_7 = 3'd7;

endpackage

/* sv/olr_setup.sv */
// line setup: octant classification, fold into octant 0, decision terms
module olr_setup import olr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  output logic        [2:0]            octant,
  output logic signed [COORD_BITS:0]   walk_x,
  output logic signed [COORD_BITS:0]   walk_y,
  output logic signed [COORD_BITS:0]   stop_x,
  output logic signed [COORD_BITS+4:0] decision,
  output logic signed [COORD_BITS+2:0] inc_straight,
  output logic signed [COORD_BITS+2:0] inc_diagonal,
  output logic                         last
);

  localparam int WW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 5;
  localparam int IW = COORD_BITS + 3;

  logic signed [WW-1:0] sx, sy, ex, ey;
  logic signed [WW-1:0] dx, dy;
  logic        [WW-1:0] adx, ady;
  logic                 dx_nneg, dy_nneg, dx_npos, dy_npos;
  logic signed [WW-1:0] x1, y1, x2, y2;
  logic signed [WW-1:0] dxz, dyz;
  logic signed [DW-1:0] dxz_d, dyz_d;
  logic signed [IW-1:0] dxz_i, dyz_i;

  assign sx = {start_x[COORD_BITS-1], start_x};
  assign sy = {start_y[COORD_BITS-1], start_y};
  assign ex = {end_x[COORD_BITS-1], end_x};
  assign ey = {end_y[COORD_BITS-1], end_y};

  assign dx  = ex - sx;
  assign dy  = ey - sy;
  assign adx = dx[WW-1] ? WW'(-dx) : WW'(dx);
  assign ady = dy[WW-1] ? WW'(-dy) : WW'(dy);

  assign dx_nneg = !dx[WW-1];
  assign dy_nneg = !dy[WW-1];
  assign dx_npos = dx[WW-1] || (dx == '0);
  assign dy_npos = dy[WW-1] || (dy == '0);

  // ties go to the lower octant of each pair
  always_comb begin
    if (dx_nneg && dy_nneg) begin
      octant = (adx >= ady) ? OCT_0 : OCT_1;
    end else if (dx_npos && dy_nneg) begin
      octant = (ady >= adx) ? OCT_2 : OCT_3;
    end else if (dx_npos && dy_npos) begin
      octant = (adx >= ady) ? OCT_4 : OCT_5;
    end else begin
      octant = (ady >= adx) ? OCT_6 : OCT_7;
    end
  end

  // fold both endpoints into octant 0
  always_comb begin
    case (octant)
      OCT_0: begin x1 = sx;  y1 = sy;  x2 = ex;  y2 = ey;  end
      OCT_1: begin x1 = sy;  y1 = sx;  x2 = ey;  y2 = ex;  end
      OCT_2: begin x1 = sy;  y1 = -sx; x2 = ey;  y2 = -ex; end
      OCT_3: begin x1 = -sx; y1 = sy;  x2 = -ex; y2 = ey;  end
      OCT_4: begin x1 = -sx; y1 = -sy; x2 = -ex; y2 = -ey; end
      OCT_5: begin x1 = -sy; y1 = -sx; x2 = -ey; y2 = -ex; end
      OCT_6: begin x1 = -sy; y1 = sx;  x2 = -ey; y2 = ex;  end
      default: begin x1 = sx; y1 = -sy; x2 = ex; y2 = -ey; end
    endcase
  end

  assign dxz = x2 - x1;
  assign dyz = y2 - y1;

  assign dxz_d = {{(DW-WW){dxz[WW-1]}}, dxz};
  assign dyz_d = {{(DW-WW){dyz[WW-1]}}, dyz};
  assign dxz_i = {{(IW-WW){dxz[WW-1]}}, dxz};
  assign dyz_i = {{(IW-WW){dyz[WW-1]}}, dyz};

  assign walk_x       = x1;
  assign walk_y       = y1;
  assign stop_x       = x2;
  assign decision     = (dyz_d <<< 1) - dxz_d;
  assign inc_straight = dyz_i <<< 1;
  assign inc_diagonal = (dyz_i - dxz_i) <<< 1;
  assign last         = (x1 >= x2);

endmodule

/* sv/octant_line_rasterizer_top.sv */
// eight-octant midpoint line rasterizer, top level
//
//   channel   dir  payload                                                  handshake
//   request   in   in_opcode in_start_x in_start_y in_end_x in_end_y        in_valid / in_stall
//   pixel     out  out_pixel_x out_pixel_y out_pixel_valid out_last_pixel  out_valid / out_stall
//
// one pixel per request, one request per clock while the pixel side does not stall
// a request passes through the request register, then setup or step logic into the pixel register
// the line state (octant, walk point, decision) updates in the same cycle the pixel register loads
// rst_n is synchronous, active low, and drops the pipeline and any active line
// out_stall holds the pixel register; in_stall rises once a request waits behind it
module octant_line_rasterizer_top import olr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_pixel_valid,
  output logic                         out_last_pixel
);

  // walk point width, decision width, increment width
  localparam int WW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 5;
  localparam int IW = COORD_BITS + 3;

  // request register
  logic                         req_valid_r, req_valid_nxt;
  logic                         req_opcode_r;
  logic signed [COORD_BITS-1:0] req_start_x_r, req_start_y_r, req_end_x_r, req_end_y_r;

  // line state
  logic        [2:0]    octant_r, octant_nxt;
  logic signed [WW-1:0] walk_x_r, walk_x_nxt;
  logic signed [WW-1:0] walk_y_r, walk_y_nxt;
  logic signed [WW-1:0] stop_x_r, stop_x_nxt;
  logic signed [DW-1:0] decision_r, decision_nxt;
  logic signed [IW-1:0] inc_straight_r, inc_straight_nxt;
  logic signed [IW-1:0] inc_diagonal_r, inc_diagonal_nxt;
  logic                 line_active_r, line_active_nxt;

  // pixel register
  logic                         out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0] pix_x_r, pix_x_nxt;
  logic signed [COORD_BITS-1:0] pix_y_r, pix_y_nxt;
  logic                         pix_valid_r, pix_valid_nxt;
  logic                         pix_last_r, pix_last_nxt;

  // setup results
  logic        [2:0]    su_octant;
  logic signed [WW-1:0] su_walk_x, su_walk_y, su_stop_x;
  logic signed [DW-1:0] su_decision;
  logic signed [IW-1:0] su_inc_straight, su_inc_diagonal;
  logic                 su_last;

  // step results
  logic                 take_diag;
  logic signed [WW-1:0] st_walk_x, st_walk_y;
  logic signed [DW-1:0] st_decision;
  logic signed [DW-1:0] inc_pick;
  logic                 st_last;

  // emit mapping
  logic signed [WW-1:0] map_x, map_y;

  logic out_free, advance, accept_in;

  // pixel register can take a new value when empty or being drained
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = req_valid_r && out_free;
  assign in_stall  = req_valid_r && !out_free;
  assign accept_in = in_valid && !in_stall;

  olr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x      (req_start_x_r),
    .start_y      (req_start_y_r),
    .end_x        (req_end_x_r),
    .end_y        (req_end_y_r),
    .octant       (su_octant),
    .walk_x       (su_walk_x),
    .walk_y       (su_walk_y),
    .stop_x       (su_stop_x),
    .decision     (su_decision),
    .inc_straight (su_inc_straight),
    .inc_diagonal (su_inc_diagonal),
    .last         (su_last)
  );

  // one midpoint step: x always advances, y on a non-negative decision
  assign take_diag   = !decision_r[DW-1];
  assign st_walk_x   = walk_x_r + WW'(1);
  assign st_walk_y   = take_diag ? walk_y_r + WW'(1) : walk_y_r;
  assign inc_pick    = take_diag ? {{(DW-IW){inc_diagonal_r[IW-1]}}, inc_diagonal_r}
                                 : {{(DW-IW){inc_straight_r[IW-1]}}, inc_straight_r};
  assign st_decision = decision_r + inc_pick;
  assign st_last     = (st_walk_x >= stop_x_r);

  // next line state
  always_comb begin
    octant_nxt       = octant_r;
    walk_x_nxt       = walk_x_r;
    walk_y_nxt       = walk_y_r;
    stop_x_nxt       = stop_x_r;
    decision_nxt     = decision_r;
    inc_straight_nxt = inc_straight_r;
    inc_diagonal_nxt = inc_diagonal_r;
    line_active_nxt  = line_active_r;
    if (advance) begin
      if (req_opcode_r == OP_START) begin
        // a start abandons any line in flight
        octant_nxt       = su_octant;
        walk_x_nxt       = su_walk_x;
        walk_y_nxt       = su_walk_y;
        stop_x_nxt       = su_stop_x;
        decision_nxt     = su_decision;
        inc_straight_nxt = su_inc_straight;
        inc_diagonal_nxt = su_inc_diagonal;
        line_active_nxt  = !su_last;
      end else if (line_active_r) begin
        walk_x_nxt      = st_walk_x;
        walk_y_nxt      = st_walk_y;
        decision_nxt    = st_decision;
        line_active_nxt = !st_last;
      end
    end
  end

  // map the new walk point back out of octant 0
  always_comb begin
    case (octant_nxt)
      OCT_0: begin map_x = walk_x_nxt;  map_y = walk_y_nxt;  end
      OCT_1: begin map_x = walk_y_nxt;  map_y = walk_x_nxt;  end
      OCT_2: begin map_x = -walk_y_nxt; map_y = walk_x_nxt;  end
      OCT_3: begin map_x = -walk_x_nxt; map_y = walk_y_nxt;  end
      OCT_4: begin map_x = -walk_x_nxt; map_y = -walk_y_nxt; end
      OCT_5: begin map_x = -walk_y_nxt; map_y = -walk_x_nxt; end
      OCT_6: begin map_x = walk_y_nxt;  map_y = -walk_x_nxt; end
      default: begin map_x = walk_x_nxt; map_y = -walk_y_nxt; end
    endcase
  end

  // next pixel
  always_comb begin
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    pix_valid_nxt = pix_valid_r;
    pix_last_nxt  = pix_last_r;
    if (advance) begin
      if ((req_opcode_r == OP_START) || line_active_r) begin
        pix_x_nxt     = map_x[COORD_BITS-1:0];
        pix_y_nxt     = map_y[COORD_BITS-1:0];
        pix_valid_nxt = 1'b1;
        pix_last_nxt  = !line_active_nxt;
      end else begin
        // step request with no line: empty pixel
        pix_x_nxt     = '0;
        pix_y_nxt     = '0;
        pix_valid_nxt = 1'b0;
        pix_last_nxt  = 1'b0;
      end
    end
  end

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (accept_in) begin
      req_valid_nxt = 1'b1;
    end else if (advance) begin
      req_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      line_active_r <= 1'b0;
    end else begin
      req_valid_r   <= req_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      line_active_r <= line_active_nxt;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (accept_in) begin
      req_opcode_r  <= in_opcode;
      req_start_x_r <= in_start_x;
      req_start_y_r <= in_start_y;
      req_end_x_r   <= in_end_x;
      req_end_y_r   <= in_end_y;
    end
  end

  // line state and pixel payload
  always_ff @(posedge clk) begin
    octant_r       <= octant_nxt;
    walk_x_r       <= walk_x_nxt;
    walk_y_r       <= walk_y_nxt;
    stop_x_r       <= stop_x_nxt;
    decision_r     <= decision_nxt;
    inc_straight_r <= inc_straight_nxt;
    inc_diagonal_r <= inc_diagonal_nxt;
    pix_x_r        <= pix_x_nxt;
    pix_y_r        <= pix_y_nxt;
    pix_valid_r    <= pix_valid_nxt;
    pix_last_r     <= pix_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pix_x_r;
  assign out_pixel_y     = pix_y_r;
  assign out_pixel_valid = pix_valid_r;
  assign out_last_pixel  = pix_last_r;

endmodule

/* sv/olr_checker.sv */
// port-level checker for the octant line rasterizer, with its bind
module olr_checker import olr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_opcode,
  input logic signed [COORD_BITS-1:0] in_start_x,
  input logic signed [COORD_BITS-1:0] in_start_y,
  input logic signed [COORD_BITS-1:0] in_end_x,
  input logic signed [COORD_BITS-1:0] in_end_y,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] out_pixel_x,
  input logic signed [COORD_BITS-1:0] out_pixel_y,
  input logic                         out_pixel_valid,
  input logic                         out_last_pixel
);

  // a stalled request keeps its payload until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_opcode) && $stable(in_start_x)
      && $stable(in_start_y) && $stable(in_end_x) && $stable(in_end_y))
    else $error("request changed while stalled");

  // held pixel stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y)
      && $stable(out_pixel_valid) && $stable(out_last_pixel))
    else $error("pixel changed while stalled");

  // an empty pixel carries all-zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |-> out_pixel_x == '0 && out_pixel_y == '0 && !out_last_pixel)
    else $error("empty pixel with nonzero fields");

  // requests back up only behind a stalled pixel
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled with the pixel side free");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pixel pending after reset");

endmodule

bind octant_line_rasterizer_top olr_checker #(.COORD_BITS(COORD_BITS)) u_olr_checker (.*);
